// ----- hw/rtl/pfts_pkg.sv -----
// pfts_pkg: shared types, codes and defaults for the priority fifo task scheduler
// used by priority_fifo_task_scheduler and the bench; depends on nothing
`default_nettype none

package pfts_pkg;

  // fixed field widths
  localparam int TASK_W = 6;
  localparam int PRIO_W = 5;
  localparam int OUTCOME_W = 3;

  // default sizes
  localparam int NUM_PRIOS_DEF = 32;
  localparam int NUM_TASKS_DEF = 64;

  // idle task after reset
  localparam logic [TASK_W-1:0] IDLE_TASK_RESET = 6'd1;

  // input modes
  localparam logic MODE_APPEND   = 1'b0;
  localparam logic MODE_SCHEDULE = 1'b1;

  // result codes
  localparam logic [OUTCOME_W-1:0] OUT_APPENDED    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_QUEUED      = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_SWITCH      = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_STAY        = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_SWITCH_IDLE = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_IDLE_STAY   = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [TASK_W-1:0] current_task;
  } in_word_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [TASK_W-1:0]    target_task;
    logic [PRIO_W-1:0]    picked_priority;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_HEAD,
    S_WALK,
    S_LINK,
    S_TAIL,
    S_FIND,
    S_POP,
    S_POPW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pfts_ram.sv -----
// pfts_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module pfts_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/priority_fifo_task_scheduler.sv -----
// priority_fifo_task_scheduler: per-priority fifo task lists with a nonempty bitmap
// depends on pfts_pkg and pfts_ram (head ram and link ram)
`default_nettype none

// channel   dir  handshake              word
// -------   ---  ---------------------  ----------------------------------------
// in        in   in_valid / in_ready    mode, task_id, priority_req, current_task
// out       out  out_valid / out_ready  outcome, target_task, picked_priority
// cfg       in   cfg_valid / cfg_ready  idle_task (6 bits), always ready
//
// one word at a time
// append: a direct write onto an empty list; on a longer list a walk to the tail, with
//   the link ram read port pacing the walk; an immediate result for task 0 or out of range
// schedule: one priority scanned per cycle from priority 0 upward, the first nonempty
//   list is popped, and the idle task is reported when every list is empty
// a finished result sits in the output register; the next word is taken meanwhile,
//   and the sequencer only stalls in its last state while that register is full
// rst is synchronous; no clearing pass, the nonempty bitmap marks valid heads

module priority_fifo_task_scheduler #(
  parameter int NUM_PRIOS = pfts_pkg::NUM_PRIOS_DEF,
  parameter int NUM_TASKS = pfts_pkg::NUM_TASKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire pfts_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pfts_pkg::out_word_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pfts_pkg::TASK_W-1:0] cfg_data
);

  localparam int PIDX_W = $clog2(NUM_PRIOS);
  localparam int TIDX_W = $clog2(NUM_TASKS);
  localparam int TASK_W = pfts_pkg::TASK_W;
  localparam int PRIO_W = pfts_pkg::PRIO_W;

  // sequencer and item state
  pfts_pkg::state_t    state, state_next;
  pfts_pkg::in_word_t  item;
  pfts_pkg::out_word_t res, res_next;
  logic [TASK_W-1:0]    node, node_next;     // walk cursor, or popped head on schedule
  logic [TIDX_W-1:0]    steps, steps_next;   // links walked so far
  logic [PIDX_W-1:0]    scan, scan_next;     // bitmap scan position
  logic [NUM_PRIOS-1:0] map, map_next;       // nonempty bitmap, also head valid bits
  logic [TASK_W-1:0]    idle_task;

  // ram ports
  logic              head_we;
  logic [PIDX_W-1:0] head_waddr, head_raddr;
  logic [TASK_W-1:0] head_wdata, head_rdata;
  logic              link_we;
  logic [TIDX_W-1:0] link_waddr, link_raddr;
  logic [TASK_W-1:0] link_wdata, link_rdata;

  // shared compare unit
  logic [TASK_W-1:0] cmp_a, cmp_b;
  logic              cmp_eq;

  logic [PIDX_W-1:0] item_prio;
  logic [TIDX_W-1:0] item_task;
  logic              task_ok, prio_ok, node_ok;
  logic [TASK_W-1:0] head_val, pop_next;
  logic              out_load;

  pfts_ram #(
    .WIDTH (TASK_W),
    .DEPTH (NUM_PRIOS)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  pfts_ram #(
    .WIDTH (TASK_W),
    .DEPTH (NUM_TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign in_ready  = (state == pfts_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign item_prio = PIDX_W'(item.priority_req);
  assign item_task = TIDX_W'(item.task_id);
  assign task_ok   = (item.task_id != '0) && (32'(item.task_id) < NUM_TASKS);
  assign prio_ok   = (32'(item.priority_req) < NUM_PRIOS);
  assign node_ok   = (32'(node) < NUM_TASKS);

  // an empty list reads as head zero whatever the ram holds
  assign head_val = map[item_prio] ? head_rdata : '0;
  // link of the popped head, zero past the task range
  assign pop_next = node_ok ? link_rdata : '0;

  // compare operands, picked by the step in progress
  always_comb begin
    unique case (state)
      pfts_pkg::S_HEAD: begin
        cmp_a = head_val;
        cmp_b = item.task_id;
      end
      pfts_pkg::S_WALK: begin
        cmp_a = link_rdata;
        cmp_b = item.task_id;
      end
      pfts_pkg::S_POPW: begin
        cmp_a = node;
        cmp_b = item.current_task;
      end
      pfts_pkg::S_FIND: begin
        cmp_a = item.current_task;
        cmp_b = idle_task;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);

  // next state, ram control and result
  always_comb begin
    state_next = state;
    node_next  = node;
    steps_next = steps;
    scan_next  = scan;
    map_next   = map;
    res_next   = res;
    head_we    = 1'b0;
    head_waddr = scan;
    head_wdata = '0;
    head_raddr = scan;
    link_we    = 1'b0;
    link_waddr = item_task;
    link_wdata = '0;
    link_raddr = TIDX_W'(node);

    unique case (state)
      pfts_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = pfts_pkg::S_START;
        end
      end

      pfts_pkg::S_START: begin
        if (item.mode == pfts_pkg::MODE_SCHEDULE) begin
          scan_next  = '0;
          state_next = pfts_pkg::S_FIND;
        end else if (!task_ok || !prio_ok) begin
          // task 0 or out of range: nothing queued
          res_next   = '{pfts_pkg::OUT_QUEUED, '0, '0};
          state_next = pfts_pkg::S_DONE;
        end else begin
          head_raddr = item_prio;
          state_next = pfts_pkg::S_HEAD;
        end
      end

      pfts_pkg::S_HEAD: begin
        if (head_val == '0) begin
          // empty list: task becomes head and tail
          head_we    = 1'b1;
          head_waddr = item_prio;
          head_wdata = item.task_id;
          link_we    = 1'b1;
          link_waddr = item_task;
          link_wdata = '0;
          map_next[item_prio] = 1'b1;
          res_next   = '{pfts_pkg::OUT_APPENDED, '0, '0};
          state_next = pfts_pkg::S_DONE;
        end else if (cmp_eq) begin
          res_next   = '{pfts_pkg::OUT_QUEUED, '0, '0};
          state_next = pfts_pkg::S_DONE;
        end else begin
          node_next  = head_val;
          steps_next = '0;
          link_raddr = TIDX_W'(head_val);
          state_next = pfts_pkg::S_WALK;
        end
      end

      pfts_pkg::S_WALK: begin
        if (link_rdata == '0) begin
          state_next = pfts_pkg::S_LINK;
        end else if (cmp_eq) begin
          res_next   = '{pfts_pkg::OUT_QUEUED, '0, '0};
          state_next = pfts_pkg::S_DONE;
        end else begin
          node_next = link_rdata;
          if (steps == TIDX_W'(NUM_TASKS - 1)) begin
            // runaway walk: link after the last node visited
            state_next = pfts_pkg::S_LINK;
          end else begin
            steps_next = steps + 1'b1;
            link_raddr = TIDX_W'(link_rdata);
          end
        end
      end

      pfts_pkg::S_LINK: begin
        if (node_ok) begin
          link_we    = 1'b1;
          link_waddr = TIDX_W'(node);
          link_wdata = item.task_id;
        end
        state_next = pfts_pkg::S_TAIL;
      end

      pfts_pkg::S_TAIL: begin
        link_we    = 1'b1;
        link_waddr = item_task;
        link_wdata = '0;
        map_next[item_prio] = 1'b1;
        res_next   = '{pfts_pkg::OUT_APPENDED, '0, '0};
        state_next = pfts_pkg::S_DONE;
      end

      pfts_pkg::S_FIND: begin
        if (map[scan]) begin
          head_raddr = scan;
          state_next = pfts_pkg::S_POP;
        end else if (scan == PIDX_W'(NUM_PRIOS - 1)) begin
          // every list empty: report the idle task
          res_next.outcome         = cmp_eq ? pfts_pkg::OUT_IDLE_STAY
                                            : pfts_pkg::OUT_SWITCH_IDLE;
          res_next.target_task     = idle_task;
          res_next.picked_priority = '0;
          state_next = pfts_pkg::S_DONE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      pfts_pkg::S_POP: begin
        node_next  = head_rdata;
        link_raddr = TIDX_W'(head_rdata);
        state_next = pfts_pkg::S_POPW;
      end

      pfts_pkg::S_POPW: begin
        head_we    = 1'b1;
        head_waddr = scan;
        head_wdata = pop_next;
        if (pop_next == '0) begin
          map_next[scan] = 1'b0;
        end
        res_next.outcome         = cmp_eq ? pfts_pkg::OUT_STAY : pfts_pkg::OUT_SWITCH;
        res_next.target_task     = node;
        res_next.picked_priority = PRIO_W'(scan);
        state_next = pfts_pkg::S_DONE;
      end

      pfts_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = pfts_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pfts_pkg::S_IDLE;
      end
    endcase
  end

  assign out_load = (state == pfts_pkg::S_DONE) && (!out_valid || out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfts_pkg::S_IDLE;
      map       <= '0;
      idle_task <= pfts_pkg::IDLE_TASK_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      map   <= map_next;
      if (cfg_valid && cfg_ready) begin
        idle_task <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    node  <= node_next;
    steps <= steps_next;
    scan  <= scan_next;
    res   <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- bench/pfts_schedule_checker.sv -----
`timescale 1ns / 100ps
// pfts_schedule_checker: watches the word channels of the task scheduler, predicts
// each result word from its own copy of the priority lists and compares; uses pfts_pkg
module pfts_schedule_checker
  import pfts_pkg::*;
#(
  parameter int NUM_PRIOS = NUM_PRIOS_DEF,
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_word_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [TASK_W-1:0] cfg_data,
  output int                fail_count,
  output int                outstanding,
  output int                results_checked,
  output logic [7:0]        outcomes_seen
);

  localparam int REPORT_MAX = 10;

  // shadow scheduler state
  logic [TASK_W-1:0]    queue_head [NUM_PRIOS];
  logic [TASK_W-1:0]    succ_task  [NUM_TASKS];
  logic [NUM_PRIOS-1:0] ready_map;
  logic [TASK_W-1:0]    shadow_idle;

  out_word_t  expected_results [$];
  int         fails = 0;
  int         checked = 0;
  logic [7:0] hits = '0;

  initial begin
    foreach (succ_task[i]) succ_task[i] = '0;
  end

  function automatic logic [TASK_W-1:0] succ(input logic [TASK_W-1:0] t);
    return (t < NUM_TASKS) ? succ_task[t] : '0;
  endfunction

  // walk list p for a duplicate and its tail, then link t behind it
  function automatic logic [OUTCOME_W-1:0] enqueue_task(input logic [TASK_W-1:0] t,
                                                        input logic [PRIO_W-1:0] p);
    logic [TASK_W-1:0] node;
    logic [TASK_W-1:0] nx;
    int                steps;
    if (t == 0 || t >= NUM_TASKS || p >= NUM_PRIOS) return OUT_QUEUED;
    node = queue_head[p];
    if (node != 0) begin
      if (node == t) return OUT_QUEUED;
      for (steps = 0; steps < NUM_TASKS; steps++) begin
        nx = succ(node);
        if (nx == 0) break;
        if (nx == t) return OUT_QUEUED;
        node = nx;
      end
      if (node < NUM_TASKS) succ_task[node] = t;
    end else begin
      queue_head[p] = t;
    end
    succ_task[t] = '0;
    ready_map[p] = 1'b1;
    return OUT_APPENDED;
  endfunction

  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t r;
    int        p;
    bit        found;
    r = '0;
    found = 1'b0;
    if (w.mode == MODE_APPEND) begin
      r.outcome = enqueue_task(w.task_id, w.priority_req);
    end else begin
      for (p = 0; p < NUM_PRIOS; p++) begin
        if (ready_map[p]) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        r.target_task = queue_head[p];
        queue_head[p] = succ(r.target_task);
        if (queue_head[p] == 0) ready_map[p] = 1'b0;
        r.picked_priority = PRIO_W'(p);
        r.outcome = (r.target_task == w.current_task) ? OUT_STAY : OUT_SWITCH;
      end else begin
        r.target_task = shadow_idle;
        r.outcome = (w.current_task == shadow_idle) ? OUT_IDLE_STAY : OUT_SWITCH_IDLE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      foreach (queue_head[i]) queue_head[i] = '0;
      ready_map = '0;
      shadow_idle = IDLE_TASK_RESET;
      expected_results.delete();
    end else begin
      // result side first: a word leaving now belongs to an older input word
      if (out_valid && out_ready) begin
        checked++;
        hits[out_data.outcome] = 1'b1;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: result word %0d with nothing pending: outcome %0d task %0d prio %0d",
                     $time, checked, out_data.outcome, out_data.target_task,
                     out_data.picked_priority);
        end else begin
          want = expected_results.pop_front();
          if (out_data.outcome !== want.outcome ||
              out_data.target_task !== want.target_task ||
              out_data.picked_priority !== want.picked_priority) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display({"%0t: result word %0d: expected outcome %0d task %0d prio %0d,",
                        " got %0d %0d %0d"},
                       $time, checked, want.outcome, want.target_task,
                       want.picked_priority, out_data.outcome, out_data.target_task,
                       out_data.picked_priority);
          end
        end
      end
      if (cfg_valid && cfg_ready) shadow_idle = cfg_data;
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
    end
    fail_count      <= fails;
    outstanding     <= expected_results.size();
    results_checked <= checked;
    outcomes_seen   <= hits;
  end

endmodule

// ----- bench/tb_priority_fifo_task_scheduler.sv -----
`timescale 1ns / 100ps
// tb_priority_fifo_task_scheduler: stimulus, pacing and verdict for the task scheduler
// depends on pfts_pkg, priority_fifo_task_scheduler and pfts_schedule_checker
module tb_priority_fifo_task_scheduler;
  import pfts_pkg::*;

  localparam int NP = NUM_PRIOS_DEF;
  localparam int NT = NUM_TASKS_DEF;
  // watchdog limit on the gap between handshakes
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int WORDS_PER_PHASE = 200;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TASK_W-1:0] cfg_data;

  int         fail_count;
  int         outstanding;
  int         results_checked;
  logic [7:0] outcomes_seen;

  // stimulus bookkeeping
  bit                no_idle = 1'b0;   // phase with back-to-back words on both sides
  logic [TASK_W-1:0] cur_idle = IDLE_TASK_RESET;
  int                sent = 0;
  int                cfg_writes = 0;
  int                stall_cycles = 0;

  priority_fifo_task_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  pfts_schedule_checker #(
    .NUM_PRIOS(NP),
    .NUM_TASKS(NT)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .outcomes_seen  (outcomes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t mk(input logic m, input int tid, input int prio, input int cur);
    in_word_t w;
    w.mode         = m;
    w.task_id      = TASK_W'(tid);
    w.priority_req = PRIO_W'(prio);
    w.current_task = TASK_W'(cur);
    return w;
  endfunction

  // random word; task and priority mostly from small pools so lists grow deep,
  // duplicates get hit and tasks land on more than one list
  function automatic in_word_t rand_word(input int append_pct);
    in_word_t w;
    int       r;
    w.mode = ($urandom_range(0, 99) < append_pct) ? MODE_APPEND : MODE_SCHEDULE;
    r = $urandom_range(0, 99);
    if (r < 70)      w.task_id = TASK_W'($urandom_range(1, 7));
    else if (r < 75) w.task_id = '0;
    else             w.task_id = TASK_W'($urandom_range(0, (1 << TASK_W) - 1));
    r = $urandom_range(0, 99);
    if (r < 55)      w.priority_req = PRIO_W'($urandom_range(0, 3));
    else if (r < 70) w.priority_req = PRIO_W'($urandom_range(NP - 4, NP - 1));
    else             w.priority_req = PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
    // running task: often the idle task or one from the pool, so stay outcomes occur
    r = $urandom_range(0, 99);
    if (r < 35)      w.current_task = cur_idle;
    else if (r < 80) w.current_task = TASK_W'($urandom_range(0, 7));
    else             w.current_task = TASK_W'($urandom_range(0, (1 << TASK_W) - 1));
    return w;
  endfunction

  // present one input word and hold it until taken; valid is only lowered for a gap
  task automatic offer(input in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // idle task write, only once every pending result word has drained
  task automatic set_idle(input logic [TASK_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NT + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    cur_idle = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // result side pacing: random stalls on out_ready
  initial begin : sink_pacing
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, stall_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TASK_W-1:0] idle_vals [PHASES];
    int                append_pct [PHASES];
    int                ph;
    int                n;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty lists with the reset idle task: switch to idle, then stay on idle
    offer(mk(MODE_SCHEDULE, 0, 0, 0));
    offer(mk(MODE_SCHEDULE, 0, 0, 1));
    // task 0 is never queued
    offer(mk(MODE_APPEND, 0, 5, 0));
    // top task on the last priority, duplicate at the head, duplicate found by the walk
    offer(mk(MODE_APPEND, 63, 31, 63));
    offer(mk(MODE_APPEND, 63, 31, 0));
    offer(mk(MODE_APPEND, 1, 31, 0));
    offer(mk(MODE_APPEND, 1, 31, 0));
    // same tasks onto priority 0 too; re-linking 63 cuts list 31 after it
    offer(mk(MODE_APPEND, 2, 0, 0));
    offer(mk(MODE_APPEND, 1, 0, 0));
    offer(mk(MODE_APPEND, 63, 0, 0));
    // drain: stay, switch, stay, then the cut list 31, then idle again
    offer(mk(MODE_SCHEDULE, 0, 0, 2));
    offer(mk(MODE_SCHEDULE, 0, 0, 0));
    offer(mk(MODE_SCHEDULE, 0, 0, 63));
    offer(mk(MODE_SCHEDULE, 0, 0, 62));
    offer(mk(MODE_SCHEDULE, 0, 0, 63));
    // three deep list with a duplicate in the middle
    offer(mk(MODE_APPEND, 5, 3, 0));
    offer(mk(MODE_APPEND, 6, 3, 0));
    offer(mk(MODE_APPEND, 7, 3, 0));
    offer(mk(MODE_APPEND, 6, 3, 0));
    offer(mk(MODE_SCHEDULE, 63, 31, 5));
    offer(mk(MODE_SCHEDULE, 63, 31, 5));
    offer(mk(MODE_SCHEDULE, 63, 31, 7));
    // idle task 0 is reported as is, then the top value
    set_idle('0);
    offer(mk(MODE_SCHEDULE, 0, 0, 0));
    offer(mk(MODE_SCHEDULE, 0, 0, 63));
    set_idle(TASK_W'(63));
    offer(mk(MODE_SCHEDULE, 0, 0, 63));

    // random phases, each under its own idle task and append mix
    idle_vals  = '{TASK_W'($urandom_range(2, 62)), TASK_W'(63), '0, TASK_W'(1),
                   TASK_W'($urandom_range(1, 63))};
    append_pct = '{50, 65, 40, 55, 35};
    for (ph = 0; ph < PHASES; ph++) begin
      set_idle(idle_vals[ph]);
      no_idle = (ph == 2);
      for (n = 0; n < WORDS_PER_PHASE; n++) offer(rand_word(append_pct[ph]));
    end
    no_idle = 1'b0;

    // drain and let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NT + 8) @(posedge clk);

    $display("run covered %0d input words, %0d idle task writes, %0d result words checked",
             sent, cfg_writes, results_checked);
    $display("outcome codes seen, one bit per code: %b", outcomes_seen[5:0]);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pfts_pkg.sv
hw/rtl/pfts_ram.sv
hw/rtl/priority_fifo_task_scheduler.sv
bench/pfts_schedule_checker.sv
bench/tb_priority_fifo_task_scheduler.sv
